// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication checked in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/tksr_pkg.sv =====
// shared constants, operation codes and control structs of the score ranker
package tksr_pkg;

   localparam int DEPTH_DEF = 10;
   localparam int SCORE_W   = 31;
   localparam int NAME_W    = 64;
   localparam int RANK_W    = 4;
   localparam int OP_W      = 2;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
   localparam logic [OP_W-1:0] OP_LIST   = 2'd2;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

   typedef struct packed {
      logic do_insert;
      logic do_clear;
      logic latch_key;
      logic idx_clear;
      logic idx_step;
      logic load_out;
      logic out_hit;
      logic out_last;
   } cmd_type;

   typedef struct packed {
      logic count_zero;
      logic idx_at_end;
      logic idx_is_last;
      logic name_match;
   } status_type;

endpackage

// ===== rtl/core/tksr_if.sv =====
// valid/ready channel interfaces for request and response beats
interface tksr_req_if import tksr_pkg::*;;
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     operation;
   logic [SCORE_W-1:0]  score;
   logic [NAME_W-1:0]   name_key;

   modport source (output valid, output operation, output score, output name_key,
                   input ready);
   modport sink (input valid, input operation, input score, input name_key,
                 output ready);
endinterface

interface tksr_rsp_if import tksr_pkg::*;;
   logic                valid;
   logic                ready;
   logic                found;
   logic [RANK_W-1:0]   rank;
   logic [SCORE_W-1:0]  entry_score;
   logic [NAME_W-1:0]   entry_name;
   logic                last;

   modport source (output valid, output found, output rank, output entry_score,
                   output entry_name, output last, input ready);
   modport sink (input valid, input found, input rank, input entry_score,
                 input entry_name, input last, output ready);
endinterface

// ===== rtl/core/tksr_datapath.sv =====
// ranked entry cells, scan index and response payload registers
module tksr_datapath import tksr_pkg::*; #(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [SCORE_W-1:0]  req_score,
   input  logic [NAME_W-1:0]   req_name_key,
   input  cmd_type             cmd,
   output status_type          status,
   output logic                rsp_found,
   output logic [RANK_W-1:0]   rsp_rank,
   output logic [SCORE_W-1:0]  rsp_entry_score,
   output logic [NAME_W-1:0]   rsp_entry_name,
   output logic                rsp_last
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [SCORE_W-1:0] score_ff [DEPTH];
   logic [NAME_W-1:0]  name_ff  [DEPTH];
   logic [SCORE_W-1:0] score_in [DEPTH];
   logic [NAME_W-1:0]  name_in  [DEPTH];
   logic [DEPTH-1:0]   valid_v;
   logic [DEPTH-1:0]   above_v;
   logic [DEPTH-1:0]   open_v;

   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [NAME_W-1:0]  key_ff;

   logic                found_ff;
   logic [RANK_W-1:0]   rank_ff;
   logic [SCORE_W-1:0]  escore_ff;
   logic [NAME_W-1:0]   ename_ff;
   logic                last_ff;

   logic [SCORE_W-1:0]  rd_score;
   logic [NAME_W-1:0]   rd_name;
   logic [RANK_W+CNT_W-1:0] rank_wide;

   // compare-and-shift cells
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      assign valid_v[g] = (CNT_W'(g) < count_ff);
      assign above_v[g] = (req_score > score_ff[g]) ||
                          ((req_score == score_ff[g]) && (req_name_key > name_ff[g]));
      assign open_v[g]  = !valid_v[g] || above_v[g];
      if (g == 0) begin : g_head
         assign score_in[g] = open_v[g] ? req_score : score_ff[g];
         assign name_in[g]  = open_v[g] ? req_name_key : name_ff[g];
      end else begin : g_body
         assign score_in[g] = !open_v[g]   ? score_ff[g] :
                              open_v[g-1]  ? score_ff[g-1] : req_score;
         assign name_in[g]  = !open_v[g]   ? name_ff[g] :
                              open_v[g-1]  ? name_ff[g-1] : req_name_key;
      end
      always_ff @(posedge clock) begin
         if (cmd.do_insert) begin
            score_ff[g] <= score_in[g];
            name_ff[g]  <= name_in[g];
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.do_clear) begin
         count_in = '0;
      end else if (cmd.do_insert && (count_ff < CNT_W'(DEPTH))) begin
         count_in = count_ff + CNT_W'(1);
      end
      idx_in = idx_ff;
      if (cmd.idx_clear) begin
         idx_in = '0;
      end else if (cmd.idx_step) begin
         idx_in = idx_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         idx_ff   <= '0;
      end else begin
         count_ff <= count_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_key) begin
         key_ff <= req_name_key;
      end
   end

   // read port at the scan index
   assign rd_score  = score_ff[idx_ff[IDX_W-1:0]];
   assign rd_name   = name_ff[idx_ff[IDX_W-1:0]];
   assign rank_wide = {{RANK_W{1'b0}}, idx_ff};

   assign status.count_zero  = (count_ff == '0);
   assign status.idx_at_end  = (idx_ff == count_ff);
   assign status.idx_is_last = (({1'b0, idx_ff} + (CNT_W + 1)'(1)) == {1'b0, count_ff});
   assign status.name_match  = (rd_name == key_ff);

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         found_ff  <= cmd.out_hit;
         rank_ff   <= cmd.out_hit ? rank_wide[RANK_W-1:0] : '0;
         escore_ff <= cmd.out_hit ? rd_score : '0;
         ename_ff  <= cmd.out_hit ? rd_name : '0;
         last_ff   <= cmd.out_last;
      end
   end

   assign rsp_found       = found_ff;
   assign rsp_rank        = rank_ff;
   assign rsp_entry_score = escore_ff;
   assign rsp_entry_name  = ename_ff;
   assign rsp_last        = last_ff;

endmodule

// ===== rtl/core/tksr_ctrl.sv =====
// operation sequencer and response valid register
module tksr_ctrl import tksr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic [OP_W-1:0]  req_operation,
   output logic             req_ready,
   input  logic             rsp_ready,
   output logic             rsp_valid,
   input  status_type       status,
   output cmd_type          cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LIST = 2'd1;
   localparam logic [1:0] ST_LOOK = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot;

   assign slot      = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_operation)
                  OP_INSERT: cmd.do_insert = 1'b1;
                  OP_CLEAR:  cmd.do_clear = 1'b1;
                  OP_LIST: begin
                     cmd.idx_clear = 1'b1;
                     state_in      = ST_LIST;
                  end
                  OP_LOOKUP: begin
                     cmd.idx_clear = 1'b1;
                     cmd.latch_key = 1'b1;
                     state_in      = ST_LOOK;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_LIST: begin
            if (slot) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               if (status.count_zero) begin
                  cmd.out_last = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  cmd.out_hit  = 1'b1;
                  cmd.out_last = status.idx_is_last;
                  cmd.idx_step = 1'b1;
                  if (status.idx_is_last) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         ST_LOOK: begin
            if (status.idx_at_end) begin
               if (slot) begin
                  cmd.load_out = 1'b1;
                  cmd.out_last = 1'b1;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else if (status.name_match) begin
               if (slot) begin
                  cmd.load_out = 1'b1;
                  cmd.out_hit  = 1'b1;
                  cmd.out_last = 1'b1;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               cmd.idx_step = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/core/top_k_score_ranker.sv =====
// top level: keeps the best DEPTH (score, name) pairs in rank order
// insert and clear: take effect at the accepting edge, ready again in the next cycle
// list: first beat goes through the ST_LIST state into the response registers, then one beat per cycle
//   as the response side takes them, so count beats, or a single not-found last beat when empty
// lookup: scans one entry per cycle through the cell read mux until a name match or the end of the list
// synchronous reset empties the list and drops any pending response beat
module top_k_score_ranker import tksr_pkg::*; #(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic   clock,
   input  logic   reset,
   tksr_req_if.sink   req_ch,
   tksr_rsp_if.source rsp_ch
);

   cmd_type    cmd;
   status_type status;

   tksr_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_ch.valid),
      .req_operation (req_ch.operation),
      .req_ready     (req_ch.ready),
      .rsp_ready     (rsp_ch.ready),
      .rsp_valid     (rsp_ch.valid),
      .status        (status),
      .cmd           (cmd)
   );

   tksr_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_score       (req_ch.score),
      .req_name_key    (req_ch.name_key),
      .cmd             (cmd),
      .status          (status),
      .rsp_found       (rsp_ch.found),
      .rsp_rank        (rsp_ch.rank),
      .rsp_entry_score (rsp_ch.entry_score),
      .rsp_entry_name  (rsp_ch.entry_name),
      .rsp_last        (rsp_ch.last)
   );

endmodule

// ===== rtl/core/tksr_checker.sv =====
// port-level checks on the score ranker, bound to the top level
`include "assert_macros.svh"

module tksr_checker import tksr_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic [OP_W-1:0]     req_operation,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic                rsp_found,
   input logic [RANK_W-1:0]   rsp_rank,
   input logic [SCORE_W-1:0]  rsp_entry_score,
   input logic [NAME_W-1:0]   rsp_entry_name,
   input logic                rsp_last
);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "response beat dropped while stalled")
   `ASSERT_CLK(a_miss_last, clock, reset, !(rsp_valid && !rsp_found) || rsp_last, "not-found beat without last")
   `ASSERT_CLK(a_miss_zero, clock, reset, !(rsp_valid && !rsp_found) || ((rsp_rank == '0) && (rsp_entry_score == '0) && (rsp_entry_name == '0)), "not-found beat with nonzero payload")
   `ASSERT_NEXT(a_quick_op, clock, reset, req_valid && req_ready && ((req_operation == OP_INSERT) || (req_operation == OP_CLEAR)), req_ready, "not ready after insert or clear")

endmodule

bind top_k_score_ranker tksr_checker u_tksr_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .req_operation   (req_ch.operation),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_found       (rsp_ch.found),
   .rsp_rank        (rsp_ch.rank),
   .rsp_entry_score (rsp_ch.entry_score),
   .rsp_entry_name  (rsp_ch.entry_name),
   .rsp_last        (rsp_ch.last)
);
